// File: sv/sar_pkg.sv
package sar_pkg;

   localparam int DEF_MAX_OUT_WIDTH  = 64;
   localparam int DEF_MAX_OUT_HEIGHT = 64;
   localparam int SUPERSAMPLE        = 2;

   localparam logic [6:0]  DIM_RESET = 7'd64;
   localparam logic [12:0] ONE_Q12   = 13'd4096;
   localparam logic [15:0] CNT_MAX   = 16'hFFFF;
   localparam logic        KIND_ADD     = 1'b0;
   localparam logic        KIND_RESOLVE = 1'b1;
   localparam logic        CSR_OUT_WIDTH  = 1'b0;
   localparam logic        CSR_OUT_HEIGHT = 1'b1;

   typedef logic [12:0] thr_arr_type [256];

   typedef struct packed {
      logic [31:0] red;
      logic [31:0] green;
      logic [31:0] blue;
      logic [31:0] alpha;
      logic [15:0] count;
   } entry_type;

   typedef struct packed {
      logic       clr;
      logic       cap;
      logic       rd_add;
      logic       rd_sub;
      logic       add_wr;
      logic       div_load;
      logic       div_step;
      logic       acc;
      logic       avg;
      logic       gam_step;
      logic       out_load;
      logic [1:0] sub;
      logic [2:0] gpos;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic req_kind;
      logic add_ok;
      logic res_ok;
      logic cnt_zero;
      logic out_free;
   } status_type;

   function automatic thr_arr_type build_thr();
      thr_arr_type  t;
      logic [159:0] k255;
      logic [159:0] lhs;
      logic [159:0] rhs;
      logic [13:0]  lo;
      logic [13:0]  hi;
      logic [13:0]  mid;
      k255 = 160'd1;
      for (int i = 0; i < 11; i++) k255 = k255 * 160'd255;
      t[0] = 13'd0;
      for (int b = 1; b < 256; b++) begin
         lhs = 160'd1;
         for (int i = 0; i < 11; i++) lhs = lhs * 160'(b);
         lhs = lhs << 60;
         lo = 14'd0;
         hi = 14'd4096;
         for (int i = 0; i < 14; i++) begin
            if (lo < hi) begin
               mid = (lo + hi) >> 1;
               rhs = k255;
               for (int j = 0; j < 5; j++) rhs = rhs * 160'(mid);
               if (lhs <= rhs) begin
                  hi = mid;
               end else begin
                  lo = mid + 14'd1;
               end
            end
         end
         t[b] = 13'(lo);
      end
      return t;
   endfunction

endpackage

// File: sv/sar_req_if.sv
interface sar_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [6:0]  column;
   logic [6:0]  row;
   logic [15:0] red;
   logic [15:0] green;
   logic [15:0] blue;
   logic [15:0] alpha;

   modport source (output valid, kind, column, row, red, green, blue, alpha, input ready);
   modport sink (input valid, kind, column, row, red, green, blue, alpha, output ready);
endinterface

// File: sv/sar_rsp_if.sv
interface sar_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_byte;
   logic [7:0] green_byte;
   logic [7:0] blue_byte;
   logic [7:0] alpha_byte;
   logic       covered;

   modport source (output valid, red_byte, green_byte, blue_byte, alpha_byte, covered,
                   input ready);
   modport sink (input valid, red_byte, green_byte, blue_byte, alpha_byte, covered,
                 output ready);
endinterface

// File: sv/sample_accumulate_resolve.sv
// Add beat: no result beat; the next beat is taken after the ADD_RD and ADD_WR states,
// or after ADD_RD alone for a sample outside the grid. Resolve beat: one result beat;
// each covered subpixel is read, loaded into four restoring dividers (one per channel) and
// accumulated; a bitwise gamma search follows the average; an unaccepted result beat stalls the last step.
// After reset the sample store is cleared, one entry per cycle, all
// 4*MAX_OUT_WIDTH*MAX_OUT_HEIGHT entries (16384 by default), before any beat.
module sample_accumulate_resolve #(
   parameter int MAX_OUT_WIDTH  = sar_pkg::DEF_MAX_OUT_WIDTH,
   parameter int MAX_OUT_HEIGHT = sar_pkg::DEF_MAX_OUT_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   sar_req_if.sink     req_chan,
   sar_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   sar_pkg::cmd_type    cmd;
   sar_pkg::status_type status;

   logic [6:0] width_ff;
   logic [6:0] height_ff;
   logic [6:0] lim_w;
   logic [6:0] lim_h;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sar_pkg::DIM_RESET;
         height_ff <= sar_pkg::DIM_RESET;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == sar_pkg::CSR_OUT_WIDTH) begin
            width_ff <= pwdata[6:0];
         end else begin
            height_ff <= pwdata[6:0];
         end
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == sar_pkg::CSR_OUT_HEIGHT) ? {25'd0, height_ff}
                                                         : {25'd0, width_ff};

   assign lim_w = (width_ff == 7'd0) ? 7'd1 :
                  (32'(width_ff) > MAX_OUT_WIDTH) ? 7'(MAX_OUT_WIDTH) : width_ff;
   assign lim_h = (height_ff == 7'd0) ? 7'd1 :
                  (32'(height_ff) > MAX_OUT_HEIGHT) ? 7'(MAX_OUT_HEIGHT) : height_ff;

   sar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sar_dp #(
      .MAX_OUT_WIDTH  (MAX_OUT_WIDTH),
      .MAX_OUT_HEIGHT (MAX_OUT_HEIGHT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .lim_w          (lim_w),
      .lim_h          (lim_h),
      .req_kind       (req_chan.kind),
      .req_column     (req_chan.column),
      .req_row        (req_chan.row),
      .req_red        (req_chan.red),
      .req_green      (req_chan.green),
      .req_blue       (req_chan.blue),
      .req_alpha      (req_chan.alpha),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_red_byte   (rsp_chan.red_byte),
      .rsp_green_byte (rsp_chan.green_byte),
      .rsp_blue_byte  (rsp_chan.blue_byte),
      .rsp_alpha_byte (rsp_chan.alpha_byte),
      .rsp_covered    (rsp_chan.covered)
   );

endmodule

// File: sv/sar_ctrl.sv
module sar_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sar_pkg::status_type status,
   output sar_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      CLEAR, IDLE, ADD_RD, ADD_WR, RES_RD, RES_LOAD, RES_DIV, RES_ACC,
      RES_AVG, RES_GAM, RES_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic [1:0]  sub_ff, sub_in;
   logic [3:0]  step_ff, step_in;
   logic [2:0]  gpos_ff, gpos_in;

   always_comb begin
      state_in  = state_ff;
      sub_in    = sub_ff;
      step_in   = step_ff;
      gpos_in   = gpos_ff;
      cmd       = '0;
      cmd.sub   = sub_ff;
      cmd.gpos  = gpos_ff;
      req_ready = 1'b0;
      case (state_ff)
         CLEAR: begin
            cmd.clr = 1'b1;
            if (status.clear_done) state_in = IDLE;
         end
         IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.cap  = 1'b1;
               sub_in   = 2'd0;
               state_in = (status.req_kind == sar_pkg::KIND_ADD) ? ADD_RD : RES_RD;
            end
         end
         ADD_RD: begin
            if (status.add_ok) begin
               cmd.rd_add = 1'b1;
               state_in   = ADD_WR;
            end else begin
               state_in = IDLE;
            end
         end
         ADD_WR: begin
            cmd.add_wr = 1'b1;
            state_in   = IDLE;
         end
         RES_RD: begin
            if (status.res_ok) begin
               cmd.rd_sub = 1'b1;
               state_in   = RES_LOAD;
            end else begin
               state_in = RES_AVG;
            end
         end
         RES_LOAD: begin
            if (status.cnt_zero) begin
               if (sub_ff == 2'd3) begin
                  state_in = RES_AVG;
               end else begin
                  sub_in   = sub_ff + 2'd1;
                  state_in = RES_RD;
               end
            end else begin
               cmd.div_load = 1'b1;
               step_in      = 4'd0;
               state_in     = RES_DIV;
            end
         end
         RES_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 4'd1;
            if (step_ff == 4'd12) state_in = RES_ACC;
         end
         RES_ACC: begin
            cmd.acc = 1'b1;
            if (sub_ff == 2'd3) begin
               state_in = RES_AVG;
            end else begin
               sub_in   = sub_ff + 2'd1;
               state_in = RES_RD;
            end
         end
         RES_AVG: begin
            cmd.avg  = 1'b1;
            gpos_in  = 3'd7;
            state_in = RES_GAM;
         end
         RES_GAM: begin
            cmd.gam_step = 1'b1;
            if (gpos_ff == 3'd0) begin
               state_in = RES_OUT;
            end else begin
               gpos_in = gpos_ff - 3'd1;
            end
         end
         RES_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
         sub_ff   <= 2'd0;
         step_ff  <= 4'd0;
         gpos_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         sub_ff   <= sub_in;
         step_ff  <= step_in;
         gpos_ff  <= gpos_in;
      end
   end

endmodule

// File: sv/sar_dp.sv
module sar_dp #(
   parameter int MAX_OUT_WIDTH  = sar_pkg::DEF_MAX_OUT_WIDTH,
   parameter int MAX_OUT_HEIGHT = sar_pkg::DEF_MAX_OUT_HEIGHT
) (
   input  logic                clock,
   input  logic                reset,
   input  sar_pkg::cmd_type    cmd,
   output sar_pkg::status_type status,
   input  logic [6:0]          lim_w,
   input  logic [6:0]          lim_h,
   input  logic                req_kind,
   input  logic [6:0]          req_column,
   input  logic [6:0]          req_row,
   input  logic [15:0]         req_red,
   input  logic [15:0]         req_green,
   input  logic [15:0]         req_blue,
   input  logic [15:0]         req_alpha,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_red_byte,
   output logic [7:0]          rsp_green_byte,
   output logic [7:0]          rsp_blue_byte,
   output logic [7:0]          rsp_alpha_byte,
   output logic                rsp_covered
);

   localparam int GRID_W = sar_pkg::SUPERSAMPLE * MAX_OUT_WIDTH;
   localparam int GRID_H = sar_pkg::SUPERSAMPLE * MAX_OUT_HEIGHT;
   localparam int GRID_N = GRID_W * GRID_H;
   localparam int AW     = $clog2(GRID_N);
   localparam sar_pkg::thr_arr_type THR = sar_pkg::build_thr();

   sar_pkg::entry_type mem [GRID_N];
   sar_pkg::entry_type rd_ff;
   sar_pkg::entry_type new_entry;

   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] add_addr;
   logic [AW-1:0] sub_addr;
   logic [AW-1:0] rd_addr;
   logic [6:0]    col_ff;
   logic [6:0]    row_ff;
   logic [15:0]   smp_ff [4];
   logic          add_ok_ff;
   logic          res_ok_ff;
   logic [7:0]    sub_row;
   logic [7:0]    sub_col;

   logic [31:0]   sum_c [4];
   logic [15:0]   cnt_ff;
   logic [15:0]   rem_ff [4];
   logic [12:0]   lo_ff [4];
   logic [12:0]   q_ff [4];
   logic          ovf_ff [4];
   logic [16:0]   div_t [4];
   logic          div_ge [4];
   logic [12:0]   mean [4];
   logic [14:0]   tot_ff [4];
   logic [2:0]    k_ff;
   logic [12:0]   v_ff [4];
   logic [12:0]   avg_in [4];
   logic [7:0]    gb_ff [3];
   logic [7:0]    cand;
   logic [31:0]   third [4];

   logic          rsp_valid_ff;
   logic [7:0]    red_ff, green_ff, blue_ff, alpha_ff;
   logic          covered_ff;
   logic [20:0]   alpha_prod;

   assign add_addr = AW'(32'(row_ff) * GRID_W + 32'(col_ff));
   assign sub_row  = {lim_h, 1'b0} - 8'd1 - ({row_ff, 1'b0} + 8'(cmd.sub[1]));
   assign sub_col  = {col_ff, 1'b0} | 8'(cmd.sub[0]);
   assign sub_addr = AW'(32'(sub_row) * GRID_W + 32'(sub_col));
   assign rd_addr  = cmd.rd_add ? add_addr : sub_addr;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + 33'(b);
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   always_comb begin
      new_entry.red   = sat_add(rd_ff.red, smp_ff[0]);
      new_entry.green = sat_add(rd_ff.green, smp_ff[1]);
      new_entry.blue  = sat_add(rd_ff.blue, smp_ff[2]);
      new_entry.alpha = sat_add(rd_ff.alpha, smp_ff[3]);
      new_entry.count = (rd_ff.count == sar_pkg::CNT_MAX) ? rd_ff.count
                                                          : rd_ff.count + 16'd1;
   end

   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         mem[clr_addr_ff] <= '0;
      end else if (cmd.add_wr) begin
         mem[add_addr] <= new_entry;
      end
      if (cmd.rd_add || cmd.rd_sub) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         col_ff    <= req_column;
         row_ff    <= req_row;
         smp_ff[0] <= req_red;
         smp_ff[1] <= req_green;
         smp_ff[2] <= req_blue;
         smp_ff[3] <= req_alpha;
         add_ok_ff <= ({1'b0, req_column} < {lim_w, 1'b0}) &&
                      ({1'b0, req_row} < {lim_h, 1'b0});
         res_ok_ff <= (req_column < lim_w) && (req_row < lim_h);
      end
   end

   always_comb begin
      sum_c[0] = rd_ff.red;
      sum_c[1] = rd_ff.green;
      sum_c[2] = rd_ff.blue;
      sum_c[3] = rd_ff.alpha;
      for (int c = 0; c < 4; c++) begin
         div_t[c]  = {rem_ff[c], lo_ff[c][12]};
         div_ge[c] = div_t[c] >= {1'b0, cnt_ff};
         mean[c]   = (ovf_ff[c] || q_ff[c] > sar_pkg::ONE_Q12) ? sar_pkg::ONE_Q12 : q_ff[c];
         third[c]  = (32'(tot_ff[c]) * 32'd43691) >> 17;
         case (k_ff)
            3'd1:    avg_in[c] = 13'(tot_ff[c]);
            3'd2:    avg_in[c] = 13'(tot_ff[c] >> 1);
            3'd3:    avg_in[c] = 13'(third[c]);
            3'd4:    avg_in[c] = 13'(tot_ff[c] >> 2);
            default: avg_in[c] = 13'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         cnt_ff <= rd_ff.count;
         for (int c = 0; c < 4; c++) begin
            ovf_ff[c] <= sum_c[c][31:13] >= {3'b000, rd_ff.count};
            rem_ff[c] <= sum_c[c][28:13];
            lo_ff[c]  <= sum_c[c][12:0];
            q_ff[c]   <= 13'd0;
         end
      end else if (cmd.div_step) begin
         for (int c = 0; c < 4; c++) begin
            rem_ff[c] <= div_ge[c] ? 16'(div_t[c] - {1'b0, cnt_ff}) : div_t[c][15:0];
            lo_ff[c]  <= {lo_ff[c][11:0], 1'b0};
            q_ff[c]   <= {q_ff[c][11:0], div_ge[c]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         k_ff <= 3'd0;
         for (int c = 0; c < 4; c++) tot_ff[c] <= 15'd0;
      end else if (cmd.acc) begin
         k_ff <= k_ff + 3'd1;
         for (int c = 0; c < 4; c++) tot_ff[c] <= tot_ff[c] + 15'(mean[c]);
      end
   end

   assign cand = 8'(1) << cmd.gpos;

   always_ff @(posedge clock) begin
      if (cmd.avg) begin
         for (int c = 0; c < 4; c++) v_ff[c] <= avg_in[c];
         for (int c = 0; c < 3; c++) gb_ff[c] <= 8'd0;
      end else if (cmd.gam_step) begin
         for (int c = 0; c < 3; c++) begin
            if (THR[gb_ff[c] | cand] <= v_ff[c]) gb_ff[c] <= gb_ff[c] | cand;
         end
      end
   end

   assign alpha_prod = 21'(v_ff[3]) * 21'd255;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         red_ff     <= gb_ff[0];
         green_ff   <= gb_ff[1];
         blue_ff    <= gb_ff[2];
         alpha_ff   <= alpha_prod[19:12];
         covered_ff <= k_ff != 3'd0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_byte   = red_ff;
   assign rsp_green_byte = green_ff;
   assign rsp_blue_byte  = blue_ff;
   assign rsp_alpha_byte = alpha_ff;
   assign rsp_covered    = covered_ff;

   assign status.clear_done = clr_addr_ff == AW'(GRID_N - 1);
   assign status.req_kind   = req_kind;
   assign status.add_ok     = add_ok_ff;
   assign status.res_ok     = res_ok_ff;
   assign status.cnt_zero   = rd_ff.count == 16'd0;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

// File: test/tb_sample_accumulate_resolve.sv
module tb_sample_accumulate_resolve;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_W = 2 * sar_pkg::DEF_MAX_OUT_WIDTH;
   localparam int GRID_N = GRID_W * 2 * sar_pkg::DEF_MAX_OUT_HEIGHT;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 100;
   localparam logic [2:0] ADDR_WIDTH = 3'd0;
   localparam logic [2:0] ADDR_HEIGHT = 3'd4;

   typedef struct packed {
      logic [7:0] red_byte;
      logic [7:0] green_byte;
      logic [7:0] blue_byte;
      logic [7:0] alpha_byte;
      logic       covered;
   } pixel_type;

   typedef struct packed {
      logic        kind;
      logic [6:0]  column;
      logic [6:0]  row;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] alpha;
      logic        typed;
      pixel_type   pixel;
   } stim_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   sar_req_if req_chan();
   sar_rsp_if rsp_chan();

   sample_accumulate_resolve dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   always #2 clock = ~clock;

   logic [31:0] acc_red [GRID_N];
   logic [31:0] acc_green [GRID_N];
   logic [31:0] acc_blue [GRID_N];
   logic [31:0] acc_alpha [GRID_N];
   logic [15:0] acc_count [GRID_N];
   logic [7:0]  gamma_lut [4097];
   logic [6:0]  width_reg = sar_pkg::DIM_RESET;
   logic [6:0]  height_reg = sar_pkg::DIM_RESET;
   pixel_type   pending_pixels [$];
   int          cycles = 0;
   int          failures = 0;
   int          rsp_stall = 0;
   bit          idling = 1'b1;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.kind = sar_pkg::KIND_ADD;
      req_chan.column = '0;
      req_chan.row = '0;
      req_chan.red = '0;
      req_chan.green = '0;
      req_chan.blue = '0;
      req_chan.alpha = '0;
      rsp_chan.ready = 1'b0;
   end

   function automatic int eff_dim(logic [6:0] raw);
      if (raw == 0) return 1;
      return raw > 64 ? 64 : int'(raw);
   endfunction

   function automatic logic [31:0] sat_sum(logic [31:0] a, logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + b;
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic int clamped_mean(logic [31:0] sum, logic [15:0] cnt);
      logic [31:0] m;
      m = sum / cnt;
      return m > 4096 ? 4096 : int'(m);
   endfunction

   function automatic void build_gamma();
      logic [159:0] p255;
      logic [159:0] rhs;
      logic [159:0] lhs;
      int b;
      p255 = 160'd1;
      for (int i = 0; i < 11; i++) p255 = p255 * 160'd255;
      b = 0;
      for (int v = 0; v <= 4096; v++) begin
         rhs = p255;
         for (int i = 0; i < 5; i++) rhs = rhs * 160'(v);
         while (b < 255) begin
            lhs = 160'd1;
            for (int i = 0; i < 11; i++) lhs = lhs * 160'(b + 1);
            lhs = lhs << 60;
            if (lhs > rhs) break;
            b++;
         end
         gamma_lut[v] = 8'(b);
      end
   endfunction

   function automatic void accumulate_sample(stim_type s);
      int a;
      if (s.column >= 2 * eff_dim(width_reg) || s.row >= 2 * eff_dim(height_reg)) return;
      a = s.row * GRID_W + s.column;
      acc_red[a] = sat_sum(acc_red[a], s.red);
      acc_green[a] = sat_sum(acc_green[a], s.green);
      acc_blue[a] = sat_sum(acc_blue[a], s.blue);
      acc_alpha[a] = sat_sum(acc_alpha[a], s.alpha);
      if (acc_count[a] != sar_pkg::CNT_MAX) acc_count[a]++;
   endfunction

   function automatic pixel_type resolve_pixel(int col, int row);
      pixel_type p;
      int tr, tg, tb, ta, k, h, sr, a;
      p = '0;
      tr = 0; tg = 0; tb = 0; ta = 0; k = 0;
      h = eff_dim(height_reg);
      if (col >= eff_dim(width_reg) || row >= h) return p;
      for (int y = 0; y < 2; y++) begin
         for (int x = 0; x < 2; x++) begin
            sr = 2 * h - 1 - (2 * row + y);
            a = sr * GRID_W + 2 * col + x;
            if (acc_count[a] != 0) begin
               k++;
               tr += clamped_mean(acc_red[a], acc_count[a]);
               tg += clamped_mean(acc_green[a], acc_count[a]);
               tb += clamped_mean(acc_blue[a], acc_count[a]);
               ta += clamped_mean(acc_alpha[a], acc_count[a]);
            end
         end
      end
      if (k != 0) begin
         tr /= k; tg /= k; tb /= k; ta /= k;
      end
      p.red_byte = gamma_lut[tr];
      p.green_byte = gamma_lut[tg];
      p.blue_byte = gamma_lut[tb];
      p.alpha_byte = 8'((ta * 255) >> 12);
      p.covered = k != 0;
      return p;
   endfunction

   task automatic send_beat(stim_type s);
      int gap;
      gap = idling ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.kind = s.kind;
      req_chan.column = s.column;
      req_chan.row = s.row;
      req_chan.red = s.red;
      req_chan.green = s.green;
      req_chan.blue = s.blue;
      req_chan.alpha = s.alpha;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (s.kind == sar_pkg::KIND_ADD) begin
         accumulate_sample(s);
      end else if (s.typed) begin
         pending_pixels.push_back(s.pixel);
      end else begin
         pending_pixels.push_back(resolve_pixel(s.column, s.row));
      end
      @(negedge clock);
   endtask

   task automatic quiesce();
      req_chan.valid = 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [6:0] value);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = addr;
      pwdata = 32'(value);
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == ADDR_WIDTH) width_reg = value;
      else height_reg = value;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   function automatic stim_type add_row(int c, int r, int vr, int vg, int vb, int va);
      stim_type s;
      s = '0;
      s.kind = sar_pkg::KIND_ADD;
      s.column = 7'(c);
      s.row = 7'(r);
      s.red = 16'(vr);
      s.green = 16'(vg);
      s.blue = 16'(vb);
      s.alpha = 16'(va);
      return s;
   endfunction

   function automatic stim_type resolve_row(int c, int r, bit typed, pixel_type p);
      stim_type s;
      s = '0;
      s.kind = sar_pkg::KIND_RESOLVE;
      s.column = 7'(c);
      s.row = 7'(r);
      s.red = 16'hFFFF;
      s.green = 16'hA5A5;
      s.blue = 16'h5A5A;
      s.alpha = 16'hFFFF;
      s.typed = typed;
      s.pixel = p;
      return s;
   endfunction

   function automatic logic [15:0] rand_channel();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 5000));
         2: return 16'hFFFF;
         default: return 16'($urandom_range(0, 4096));
      endcase
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_stall <= idling ? $urandom_range(0, 10) : 0;
         if (pending_pixels.size() == 0) begin
            $error("result beat with nothing expected");
            failures++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_chan.red_byte !== want.red_byte) begin
               $error("red_byte expected %0d got %0d", want.red_byte, rsp_chan.red_byte);
               failures++;
            end
            if (rsp_chan.green_byte !== want.green_byte) begin
               $error("green_byte expected %0d got %0d", want.green_byte, rsp_chan.green_byte);
               failures++;
            end
            if (rsp_chan.blue_byte !== want.blue_byte) begin
               $error("blue_byte expected %0d got %0d", want.blue_byte, rsp_chan.blue_byte);
               failures++;
            end
            if (rsp_chan.alpha_byte !== want.alpha_byte) begin
               $error("alpha_byte expected %0d got %0d", want.alpha_byte, rsp_chan.alpha_byte);
               failures++;
            end
            if (rsp_chan.covered !== want.covered) begin
               $error("covered expected %0d got %0d", want.covered, rsp_chan.covered);
               failures++;
            end
         end
      end
   end

   initial begin
      stim_type    directed [$];
      stim_type    s;
      pixel_type   zero_pix;
      pixel_type   full_pix;
      logic [6:0]  widths [6];
      logic [6:0]  heights [6];
      int          w, h;
      for (int i = 0; i < GRID_N; i++) begin
         acc_red[i] = '0;
         acc_green[i] = '0;
         acc_blue[i] = '0;
         acc_alpha[i] = '0;
         acc_count[i] = '0;
      end
      build_gamma();
      zero_pix = '0;
      full_pix = {8'd255, 8'd255, 8'd255, 8'd255, 1'b1};
      widths = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd5, 7'd64};
      heights = '{7'd64, 7'd1, 7'd0, 7'd100, 7'd3, 7'd2};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed.push_back(resolve_row(0, 0, 1, zero_pix));
      directed.push_back(resolve_row(127, 127, 1, zero_pix));
      directed.push_back(resolve_row(64, 0, 1, zero_pix));
      directed.push_back(add_row(0, 127, 4096, 4096, 4096, 4096));
      directed.push_back(resolve_row(0, 0, 1, full_pix));
      directed.push_back(add_row(1, 127, 0, 0, 0, 0));
      directed.push_back(resolve_row(0, 0, 0, zero_pix));
      directed.push_back(add_row(0, 126, 65535, 65535, 65535, 65535));
      directed.push_back(resolve_row(0, 0, 0, zero_pix));
      directed.push_back(add_row(127, 0, 65535, 65535, 65535, 65535));
      directed.push_back(resolve_row(63, 63, 1, full_pix));
      directed.push_back(add_row(126, 0, 1, 0, 65535, 32768));
      directed.push_back(resolve_row(63, 63, 0, zero_pix));
      directed.push_back(add_row(126, 1, 0, 2048, 100, 4095));
      directed.push_back(resolve_row(63, 63, 0, zero_pix));
      directed.push_back(resolve_row(63, 64, 1, zero_pix));
      foreach (directed[i]) send_beat(directed[i]);
      quiesce();

      // Drive one subpixel back to back with samples far above one so its mean is clamped.
      idling = 1'b0;
      for (int i = 0; i < 20; i++) send_beat(add_row(5, 5, 65535, 65535, 65535, 65535));
      send_beat(resolve_row(2, 61, 1, full_pix));
      quiesce();

      for (int p = 0; p < 6; p++) begin
         csr_write(ADDR_WIDTH, widths[p]);
         csr_write(ADDR_HEIGHT, heights[p]);
         idling = (p % 2) == 0;
         w = eff_dim(width_reg);
         h = eff_dim(height_reg);
         for (int i = 0; i < 240; i++) begin
            s = '0;
            if ($urandom_range(0, 9) < 6) begin
               s.kind = sar_pkg::KIND_ADD;
               if ($urandom_range(0, 9) < 9) begin
                  s.column = 7'($urandom_range(0, 2 * w - 1));
                  s.row = 7'($urandom_range(0, 2 * h - 1));
               end else begin
                  s.column = 7'($urandom);
                  s.row = 7'($urandom);
               end
               s.red = rand_channel();
               s.green = rand_channel();
               s.blue = rand_channel();
               s.alpha = rand_channel();
            end else begin
               s.kind = sar_pkg::KIND_RESOLVE;
               if ($urandom_range(0, 9) < 9) begin
                  s.column = 7'($urandom_range(0, w - 1));
                  s.row = 7'($urandom_range(0, h - 1));
               end else begin
                  s.column = 7'($urandom);
                  s.row = 7'($urandom);
               end
               s.red = 16'($urandom);
               s.green = 16'($urandom);
               s.blue = 16'($urandom);
               s.alpha = 16'($urandom);
            end
            send_beat(s);
         end
         quiesce();
      end

      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
